@@ rtl/rtf_pkg.sv @@
// Package with shared types, codes and helper functions of the ramp-to-failure controller.
`default_nettype none

package rtf_pkg;

  // Widths of the item fields and configuration registers.
  localparam int unsigned FORCE_W = 24;
  localparam int unsigned POS_W   = 23;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned PROD_W  = FORCE_W + PCT_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = POS_W;

  // Scale that turns a force magnitude into percent units.
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_BEHAVIOUR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_PERCENT           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SPEED             = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD_DISTANCE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_AFTER_FAILURE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_TOLERANCE     = 3'd5;

  // Input actions.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_FORCE = 2'd2,
    ACT_DIST  = 2'd3
  } action_t;

  // Stage commands.
  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_BACKWARD = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_GOTO     = 2'd3
  } cmd_t;

  // Behaviour after a failure is detected.
  typedef enum logic [1:0] {
    BHV_RETURN = 2'd0,
    BHV_STOP   = 2'd1,
    BHV_GOTO   = 2'd2
  } behaviour_t;

  // Controller phases.
  typedef enum logic [1:0] {
    PH_STOPPED   = 2'd0,
    PH_RAMPING   = 2'd1,
    PH_RETURNING = 2'd2
  } phase_t;

  // Configuration register set.
  typedef struct packed {
    logic [1:0]         failure_behaviour;
    logic [PCT_W-1:0]   drop_percent;
    logic [SPEED_W-1:0] ramp_speed;
    logic [POS_W-1:0]   preload_distance;
    logic [POS_W-1:0]   distance_after_failure;
    logic [TOL_W-1:0]   distance_tolerance;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [1:0]                action;
    logic signed [FORCE_W-1:0] force_sample;
    logic [POS_W-1:0]          distance_sample;
  } item_t;

  // One result word.
  typedef struct packed {
    cmd_t               command;
    logic [POS_W-1:0]   target_position;
    logic [SPEED_W-1:0] drive_speed;
    logic               finished;
  } res_t;

  // Magnitude of a signed force; the most negative value maps to 2^23 without loss.
  function automatic logic [FORCE_W-1:0] force_mag(input logic signed [FORCE_W-1:0] v);
    logic [FORCE_W-1:0] u;
    u = v;
    return v[FORCE_W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rtf_if.sv @@
// Valid/ready channel interfaces for input words and result words.
`default_nettype none

interface rtf_in_if
  import rtf_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic signed [FORCE_W-1:0] force_sample;
  logic [POS_W-1:0]          distance_sample;

  modport source (output valid, action, force_sample, distance_sample, input ready);
  modport sink   (input valid, action, force_sample, distance_sample, output ready);
endinterface

interface rtf_out_if
  import rtf_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [POS_W-1:0]   target_position;
  logic [SPEED_W-1:0] drive_speed;
  logic               finished;

  modport source (output valid, command, target_position, drive_speed, finished,
                  input ready);
  modport sink   (input valid, command, target_position, drive_speed, finished,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/rtf_cfg_regs.sv @@
// Configuration register file of the ramp-to-failure controller.
`default_nettype none

module rtf_cfg_regs
  import rtf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and merge the write data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAILURE_BEHAVIOUR:      cfg_nxt.failure_behaviour = cfg_wdata[1:0];
        CFG_DROP_PERCENT:           cfg_nxt.drop_percent = cfg_wdata[PCT_W-1:0];
        CFG_RAMP_SPEED:             cfg_nxt.ramp_speed = cfg_wdata[SPEED_W-1:0];
        CFG_PRELOAD_DISTANCE:       cfg_nxt.preload_distance = cfg_wdata[POS_W-1:0];
        CFG_DISTANCE_AFTER_FAILURE: cfg_nxt.distance_after_failure = cfg_wdata[POS_W-1:0];
        CFG_DISTANCE_TOLERANCE:     cfg_nxt.distance_tolerance = cfg_wdata[TOL_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register set with its reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.failure_behaviour      <= BHV_STOP;
      cfg_r.drop_percent           <= 7'd50;
      cfg_r.ramp_speed             <= 16'd100;
      cfg_r.preload_distance       <= '0;
      cfg_r.distance_after_failure <= '0;
      cfg_r.distance_tolerance     <= 16'd101;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/rtf_step.sv @@
// Phase state machine and peak-force tracking that turn one input word into one result word.
`default_nettype none

module rtf_step
  import rtf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  go,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  phase_t                    phase_r;
  phase_t                    phase_nxt;
  logic signed [FORCE_W-1:0] peak_r;
  logic signed [FORCE_W-1:0] peak_nxt;
  logic [FORCE_W-1:0]        sample_mag;
  logic [FORCE_W-1:0]        peak_mag;
  logic [FORCE_W-1:0]        peak_nxt_mag;
  logic [PROD_W-1:0]         scaled_sample;
  logic [PROD_W-1:0]         drop_level;
  logic                      is_failure;
  logic [POS_W-1:0]          arrive_target;
  logic                      arrive_armed;
  logic [POS_W-1:0]          pos_err;
  logic                      arrived;

  // Peak tracking: keep the sample of largest magnitude.
  always_comb begin
    sample_mag = force_mag(item.force_sample);
    peak_mag   = force_mag(peak_r);
    peak_nxt   = peak_r;
    if (item.action == ACT_FORCE && sample_mag > peak_mag) begin
      peak_nxt = item.force_sample;
    end
    peak_nxt_mag = force_mag(peak_nxt);
  end

  // Failure test against the updated peak, both sides in percent units.
  assign scaled_sample = PROD_W'(sample_mag) * PROD_W'(PCT_SCALE);
  assign drop_level    = PROD_W'(cfg.drop_percent) * PROD_W'(peak_nxt_mag);
  assign is_failure    = scaled_sample < drop_level;

  // Arrival test for the return move; only return and go-to behaviours have a target.
  always_comb begin
    arrive_target = cfg.preload_distance;
    arrive_armed  = 1'b0;
    case (cfg.failure_behaviour)
      BHV_RETURN: begin
        arrive_target = cfg.preload_distance;
        arrive_armed  = 1'b1;
      end
      BHV_GOTO: begin
        arrive_target = cfg.distance_after_failure;
        arrive_armed  = 1'b1;
      end
      default: arrive_armed = 1'b0;
    endcase
    pos_err = (arrive_target > item.distance_sample) ? arrive_target - item.distance_sample
                                                     : item.distance_sample - arrive_target;
    arrived = arrive_armed && (pos_err < POS_W'(cfg.distance_tolerance));
  end

  // Next phase and result word.
  always_comb begin
    phase_nxt           = phase_r;
    res.command         = CMD_NONE;
    res.target_position = '0;
    res.drive_speed     = '0;
    res.finished        = 1'b0;
    unique case (phase_r)
      PH_RAMPING: begin
        if (item.action == ACT_STOP) begin
          res.command  = CMD_STOP;
          res.finished = 1'b1;
          phase_nxt    = PH_STOPPED;
        end else if (item.action == ACT_FORCE && is_failure) begin
          case (cfg.failure_behaviour)
            BHV_RETURN: begin
              res.command         = CMD_GOTO;
              res.target_position = cfg.preload_distance;
              phase_nxt           = PH_RETURNING;
            end
            BHV_STOP: begin
              res.command  = CMD_STOP;
              res.finished = 1'b1;
              phase_nxt    = PH_STOPPED;
            end
            BHV_GOTO: begin
              res.command         = CMD_GOTO;
              res.target_position = cfg.distance_after_failure;
              phase_nxt           = PH_RETURNING;
            end
            default: phase_nxt = PH_RAMPING;
          endcase
        end
      end
      PH_RETURNING: begin
        if (item.action == ACT_DIST && arrived) begin
          res.finished = 1'b1;
          phase_nxt    = PH_STOPPED;
        end
      end
      default: begin
        if (item.action == ACT_START) begin
          res.command     = CMD_BACKWARD;
          res.drive_speed = cfg.ramp_speed;
          phase_nxt       = PH_RAMPING;
        end
      end
    endcase
  end

  // State registers advance once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STOPPED;
      peak_r  <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      peak_r  <= peak_nxt;
    end
  end

  // A start that issues a backward move leaves the controller ramping.
  assert property (@(posedge clk) disable iff (!rst_n)
    go && res.command == CMD_BACKWARD |=> phase_r == PH_RAMPING)
    else $error("backward move did not enter ramping");

  // Every finished result leaves the controller stopped.
  assert property (@(posedge clk) disable iff (!rst_n)
    go && res.finished |=> phase_r == PH_STOPPED)
    else $error("finished result did not stop the controller");

  // The peak magnitude never shrinks.
  assert property (@(posedge clk) disable iff (!rst_n)
    go |=> peak_mag >= $past(peak_mag))
    else $error("peak force magnitude decreased");

endmodule

`default_nettype wire

@@ rtl/ramp_to_failure_controller.sv @@
// Top level of the ramp-to-failure controller: input register, step logic and result register.
//
// Usage: input words (action, force_sample, distance_sample) arrive on in_ch, a valid/ready
// channel; every accepted word yields exactly one result word (command, target_position,
// drive_speed, finished) on out_ch, in order. A start word while stopped issues a backward
// move at ramp_speed; force samples update the peak force and, while ramping, detect a
// failure when the force falls below drop_percent of the peak; distance samples end the
// return move once within distance_tolerance of the target.
// Path: an accepted word waits in the input register, then its result in the result register.
// Throughput: one word per cycle while out_ch takes results; the input register feeds a compare
// and two small multiplies that update the phase and peak registers, then the result register.
// Stall: when out_ch is held off, the result register keeps its word and the input register
// takes one more word; in_ch.ready falls only when both registers are full.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the block is idle.
// Reset (rst_n low at a clock edge) empties both registers, sets the phase to stopped, clears
// the peak force and loads the configuration reset values.
`default_nettype none

module ramp_to_failure_controller
  import rtf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rtf_in_if.sink                     in_ch,
  rtf_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item_r;
  item_t item_nxt;
  logic  item_valid_r;
  logic  item_valid_nxt;
  res_t  res;
  res_t  out_r;
  logic  out_valid_r;
  logic  out_valid_nxt;
  logic  out_free;
  logic  step_go;
  logic  in_take;

  rtf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rtf_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (step_go),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Handshake: a word moves on whenever the stage ahead is empty or draining.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign step_go      = item_valid_r && out_free;
  assign in_ch.ready  = !item_valid_r || step_go;
  assign in_take      = in_ch.valid && in_ch.ready;

  // Next values of the input register.
  always_comb begin
    item_nxt.action          = in_ch.action;
    item_nxt.force_sample    = in_ch.force_sample;
    item_nxt.distance_sample = in_ch.distance_sample;
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (step_go) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end
  end

  // Next valid of the result register.
  always_comb begin
    if (step_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
    if (step_go) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.command         = out_r.command;
  assign out_ch.target_position = out_r.target_position;
  assign out_ch.drive_speed     = out_r.drive_speed;
  assign out_ch.finished        = out_r.finished;

  // Input is held off only when both registers hold a word.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> item_valid_r && out_valid_r)
    else $error("input stalled with a free register");

  // A word that waits in the input register while the output stalls is still there next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !out_free |=> item_valid_r && $stable(item_r))
    else $error("waiting input word was lost");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the ramp-to-failure controller with its own prediction of every result word.
module tb;
  import rtf_pkg::*;

  // Failure behaviour code with no meaning; a failure is then ignored.
  localparam logic [1:0] BHV_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned FORCE_MAG_MAX = 8388608;
  localparam int unsigned POS_MAX = 8388607;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rtf_in_if in_ch();
  rtf_out_if out_ch();

  ramp_to_failure_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the controller registers and state.
  cfg_t regs;
  phase_t stage_phase;
  logic signed [FORCE_W-1:0] peak_force;

  res_t pending_replies[$];
  int errors = 0;
  int unsigned words_sent = 0;
  bit idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of a force, one bit wider so the most negative value fits.
  function automatic logic [FORCE_W:0] force_abs(input logic signed [FORCE_W-1:0] v);
    logic signed [FORCE_W:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic bit near_target(input logic [POS_W-1:0] target, input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] d;
    d = (target > pos) ? target - pos : pos - target;
    return d < regs.distance_tolerance;
  endfunction

  // Target of the return move under the current behaviour.
  function automatic logic [POS_W-1:0] return_target();
    return (regs.failure_behaviour == BHV_GOTO) ? regs.distance_after_failure
                                                 : regs.preload_distance;
  endfunction

  // Smallest force magnitude that does not count as failure against the current peak.
  function automatic int unsigned fail_ceiling();
    return (regs.drop_percent * force_abs(peak_force) + 99) / 100;
  endfunction

  // Expected result word of one input word; advances the shadow state.
  function automatic res_t predict_stage_reply(input item_t w);
    res_t r;
    longint unsigned scaled_force;
    longint unsigned threshold;
    bit done;
    r = '0;
    r.command = CMD_NONE;
    if (w.action == ACT_FORCE && force_abs(w.force_sample) > force_abs(peak_force))
      peak_force = w.force_sample;
    case (stage_phase)
      PH_RAMPING: begin
        if (w.action == ACT_STOP) begin
          r.command = CMD_STOP;
          r.finished = 1'b1;
          stage_phase = PH_STOPPED;
        end else if (w.action == ACT_FORCE) begin
          scaled_force = force_abs(w.force_sample) * 100;
          threshold = regs.drop_percent * force_abs(peak_force);
          if (scaled_force < threshold) begin
            case (regs.failure_behaviour)
              BHV_RETURN: begin
                r.command = CMD_GOTO;
                r.target_position = regs.preload_distance;
                stage_phase = PH_RETURNING;
              end
              BHV_STOP: begin
                r.command = CMD_STOP;
                r.finished = 1'b1;
                stage_phase = PH_STOPPED;
              end
              BHV_GOTO: begin
                r.command = CMD_GOTO;
                r.target_position = regs.distance_after_failure;
                stage_phase = PH_RETURNING;
              end
              default: ;
            endcase
          end
        end
      end
      PH_RETURNING: begin
        if (w.action == ACT_DIST) begin
          done = 1'b0;
          if (regs.failure_behaviour == BHV_RETURN)
            done = near_target(regs.preload_distance, w.distance_sample);
          else if (regs.failure_behaviour == BHV_GOTO)
            done = near_target(regs.distance_after_failure, w.distance_sample);
          if (done) begin
            r.finished = 1'b1;
            stage_phase = PH_STOPPED;
          end
        end
      end
      default: begin
        if (w.action == ACT_START) begin
          r.command = CMD_BACKWARD;
          r.drive_speed = regs.ramp_speed;
          stage_phase = PH_RAMPING;
        end
      end
    endcase
    return r;
  endfunction

  // Present one word, wait for its handshake and record its expected result.
  task automatic send_word(input action_t act, input logic signed [FORCE_W-1:0] f,
                           input logic [POS_W-1:0] d);
    item_t w;
    int unsigned gap;
    w.action = act;
    w.force_sample = f;
    w.distance_sample = d;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.action = w.action;
    in_ch.force_sample = w.force_sample;
    in_ch.distance_sample = w.distance_sample;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_replies.push_back(predict_stage_reply(w));
    words_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Register write, only once every outstanding result has come back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    while (pending_replies.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_FAILURE_BEHAVIOUR:      regs.failure_behaviour = value[1:0];
      CFG_DROP_PERCENT:           regs.drop_percent = value[PCT_W-1:0];
      CFG_RAMP_SPEED:             regs.ramp_speed = value[SPEED_W-1:0];
      CFG_PRELOAD_DISTANCE:       regs.preload_distance = value[POS_W-1:0];
      CFG_DISTANCE_AFTER_FAILURE: regs.distance_after_failure = value[POS_W-1:0];
      CFG_DISTANCE_TOLERANCE:     regs.distance_tolerance = value[TOL_W-1:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_value(input int unsigned hi);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return hi;
      default: return $urandom_range(hi, 0);
    endcase
  endfunction

  // Force with the given magnitude and a random sign; the full magnitude is always negative.
  function automatic logic signed [FORCE_W-1:0] force_of_mag(input int unsigned m);
    logic signed [FORCE_W-1:0] f;
    if (m >= FORCE_MAG_MAX)
      return {1'b1, {(FORCE_W-1){1'b0}}};
    f = m[FORCE_W-1:0];
    return $urandom_range(0, 1) ? -f : f;
  endfunction

  // Position at the given offset from a target, kept inside the stage range.
  function automatic logic [POS_W-1:0] pos_near(input int unsigned t, input int unsigned off);
    int unsigned s;
    if ($urandom_range(0, 1) && t >= off)
      s = t - off;
    else if (t + off <= POS_MAX)
      s = t + off;
    else
      s = t - off;
    return s[POS_W-1:0];
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side: random stalls, one draw per word.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual command %0d",
                 $time, out_ch.command);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        check_field("command", want.command, out_ch.command);
        check_field("target_position", want.target_position, out_ch.target_position);
        check_field("drive_speed", want.drive_speed, out_ch.drive_speed);
        check_field("finished", want.finished, out_ch.finished);
      end
    end
  end

  // Start and stop, and words that have no effect in the current phase.
  task automatic test_start_stop();
    send_word(ACT_START, '0, '0);
    send_word(ACT_START, '0, '0);
    send_word(ACT_DIST, '0, '0);
    send_word(ACT_STOP, '0, '0);
    send_word(ACT_STOP, '0, '0);
  endtask

  // Extreme forces with the reset settings; a zero force then fails and stops.
  task automatic test_force_extremes();
    send_word(ACT_START, '0, '0);
    send_word(ACT_FORCE, {1'b1, {(FORCE_W-1){1'b0}}}, '0);
    send_word(ACT_FORCE, {1'b0, {(FORCE_W-1){1'b1}}}, '0);
    send_word(ACT_FORCE, '0, '0);
  endtask

  // Full drop percent, top speed and the farthest preload; arrival just inside tolerance.
  task automatic test_return_to_preload();
    write_reg(CFG_FAILURE_BEHAVIOUR, BHV_RETURN);
    write_reg(CFG_DROP_PERCENT, 100);
    write_reg(CFG_RAMP_SPEED, 65535);
    write_reg(CFG_PRELOAD_DISTANCE, POS_MAX);
    write_reg(CFG_DISTANCE_TOLERANCE, 65535);
    send_word(ACT_START, '0, '0);
    send_word(ACT_FORCE, {1'b0, {(FORCE_W-1){1'b1}}}, '0);
    send_word(ACT_DIST, '0, POS_W'(POS_MAX - 65535));
    send_word(ACT_DIST, '0, POS_W'(POS_MAX - 65534));
  endtask

  // Go to a set distance of zero with the tightest useful tolerance and zero speed.
  task automatic test_goto_distance();
    write_reg(CFG_FAILURE_BEHAVIOUR, BHV_GOTO);
    write_reg(CFG_DISTANCE_AFTER_FAILURE, 0);
    write_reg(CFG_DISTANCE_TOLERANCE, 1);
    write_reg(CFG_DROP_PERCENT, 50);
    write_reg(CFG_RAMP_SPEED, 0);
    send_word(ACT_START, '0, '0);
    send_word(ACT_FORCE, '0, '0);
    send_word(ACT_DIST, '0, POS_W'(1));
    send_word(ACT_DIST, '0, '0);
  endtask

  // Unused behaviour code ignores failure; stop and unused codes never arrive while returning.
  task automatic test_unused_behaviour();
    write_reg(CFG_FAILURE_BEHAVIOUR, BHV_UNUSED);
    write_reg(CFG_RAMP_SPEED, 100);
    send_word(ACT_START, '0, '0);
    send_word(ACT_FORCE, '0, '0);
    send_word(ACT_STOP, '0, '0);
    write_reg(CFG_FAILURE_BEHAVIOUR, BHV_RETURN);
    write_reg(CFG_PRELOAD_DISTANCE, 100);
    send_word(ACT_START, '0, '0);
    send_word(ACT_FORCE, '0, '0);
    write_reg(CFG_FAILURE_BEHAVIOUR, BHV_STOP);
    send_word(ACT_DIST, '0, POS_W'(100));
    write_reg(CFG_FAILURE_BEHAVIOUR, BHV_UNUSED);
    send_word(ACT_DIST, '0, POS_W'(100));
    write_reg(CFG_FAILURE_BEHAVIOUR, BHV_RETURN);
    send_word(ACT_DIST, '0, POS_W'(100));
  endtask

  // New random settings between experiments; extremes come up often.
  task automatic randomize_settings();
    write_reg(CFG_FAILURE_BEHAVIOUR,
              ($urandom_range(0, 19) == 0) ? BHV_UNUSED : $urandom_range(0, 2));
    if ($urandom_range(0, 1))
      write_reg(CFG_DROP_PERCENT, pick_value(100));
    if ($urandom_range(0, 1))
      write_reg(CFG_RAMP_SPEED, pick_value(65535));
    if ($urandom_range(0, 1))
      write_reg(CFG_PRELOAD_DISTANCE, pick_value(POS_MAX));
    if ($urandom_range(0, 1))
      write_reg(CFG_DISTANCE_AFTER_FAILURE, pick_value(POS_MAX));
    if ($urandom_range(0, 1))
      write_reg(CFG_DISTANCE_TOLERANCE,
                ($urandom_range(0, 3) == 0) ? pick_value(65535) : $urandom_range(1, 2000));
  endtask

  // Random experiments: start, ramp, failure or stop, return, with stray words mixed in.
  task automatic test_random_ramps();
    int unsigned goal;
    int unsigned steps;
    int unsigned ramp_left;
    int unsigned lo;
    int unsigned tgt;
    int unsigned fmag;
    bit started;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      randomize_settings();
      idle_on = ($urandom_range(0, 3) != 0);
      ramp_left = $urandom_range(1, 6);
      started = 1'b0;
      for (steps = 0; steps < 40 && !(started && stage_phase == PH_STOPPED); steps++) begin
        lo = fail_ceiling();
        if ($urandom_range(0, 9) == 0) begin
          send_word(action_t'($urandom_range(0, 3)), FORCE_W'($urandom), POS_W'($urandom));
        end else begin
          case (stage_phase)
            PH_RAMPING: begin
              if (ramp_left != 0) begin
                fmag = ($urandom_range(0, 3) == 0) ? lo : $urandom_range(FORCE_MAG_MAX, lo);
                send_word(ACT_FORCE, force_of_mag(fmag), POS_W'($urandom));
                ramp_left--;
              end else if (lo == 0 || $urandom_range(0, 6) == 0) begin
                send_word(ACT_STOP, FORCE_W'($urandom), POS_W'($urandom));
              end else begin
                fmag = $urandom_range(0, 1) ? lo - 1 : $urandom_range(lo - 1, 0);
                send_word(ACT_FORCE, force_of_mag(fmag), POS_W'($urandom));
              end
            end
            PH_RETURNING: begin
              // A return that could never arrive is given a usable setting first.
              if (regs.distance_tolerance == 0 ||
                  !(regs.failure_behaviour == BHV_RETURN ||
                    regs.failure_behaviour == BHV_GOTO)) begin
                write_reg(CFG_FAILURE_BEHAVIOUR, $urandom_range(0, 1) ? BHV_RETURN : BHV_GOTO);
                write_reg(CFG_DISTANCE_TOLERANCE, $urandom_range(1, 2000));
              end
              tgt = return_target();
              case ($urandom_range(0, 2))
                0: send_word(ACT_DIST, FORCE_W'($urandom),
                             pos_near(tgt, $urandom_range(regs.distance_tolerance - 1, 0)));
                1: send_word(ACT_DIST, FORCE_W'($urandom),
                             pos_near(tgt, regs.distance_tolerance));
                default: send_word(ACT_DIST, FORCE_W'($urandom), POS_W'($urandom));
              endcase
            end
            default: begin
              send_word(ACT_START, FORCE_W'($urandom), POS_W'($urandom));
              started = 1'b1;
            end
          endcase
        end
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_START;
    in_ch.force_sample = '0;
    in_ch.distance_sample = '0;
    regs.failure_behaviour = BHV_STOP;
    regs.drop_percent = 50;
    regs.ramp_speed = 100;
    regs.preload_distance = '0;
    regs.distance_after_failure = '0;
    regs.distance_tolerance = 101;
    stage_phase = PH_STOPPED;
    peak_force = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_start_stop();
    test_force_extremes();
    test_return_to_preload();
    test_goto_distance();
    test_unused_behaviour();
    test_random_ramps();

    // Let every outstanding word drain, then wait on for anything stray.
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rtf_pkg.sv
rtl/rtf_if.sv
rtl/rtf_cfg_regs.sv
rtl/rtf_step.sv
rtl/ramp_to_failure_controller.sv
dv/tb.sv
